### design/grid_face_triangle_generator_macros.svh
// Assertion macros for the grid face triangle generator.
`ifndef GRID_FACE_TRIANGLE_GENERATOR_MACROS_SVH
`define GRID_FACE_TRIANGLE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define GFTG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GFTG_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define GFTG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define GFTG_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### design/gftg_pkg.sv
// Shared types, constants and vertex offset table of the grid face triangle generator.
`default_nettype none
package gftg_pkg;

   localparam int unsigned CELLS_W = 8;
   localparam int unsigned SIZE_W  = 16;
   localparam int unsigned IDX_W   = CELLS_W + 1;
   localparam int unsigned COORD_W = 24;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [CELLS_W-1:0] CELLS_RESET = CELLS_W'(1);
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(256);

   typedef enum logic [1:0] {
      FACE_XY = 2'd0,
      FACE_YZ = 2'd1,
      FACE_XZ = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELLS_X   = 8'd0,
      CSR_CELLS_Y   = 8'd1,
      CSR_CELLS_Z   = 8'd2,
      CSR_CELL_SIZE = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [CELLS_W-1:0] cells_x;
      logic [CELLS_W-1:0] cells_y;
      logic [CELLS_W-1:0] cells_z;
      logic [SIZE_W-1:0]  cell_size;
   } cfg_type;

   // grid indices of the three vertices, axis 0 x, 1 y, 2 z
   typedef struct packed {
      logic [2:0][2:0][IDX_W-1:0] vidx;
      logic [1:0]                 group;
      logic                       last;
   } tri_type;

   // offsets {di,dj,dk} of each vertex, vertex 0 in the low bits
   function automatic logic [2:0][2:0] vert_off(input logic [1:0] ph, input logic half);
      logic [2:0][2:0] off;
      unique case ({ph, half})
         {FACE_XY, 1'b0}: off = {3'b110, 3'b010, 3'b000};
         {FACE_XY, 1'b1}: off = {3'b100, 3'b110, 3'b000};
         {FACE_YZ, 1'b0}: off = {3'b001, 3'b010, 3'b000};
         {FACE_YZ, 1'b1}: off = {3'b011, 3'b010, 3'b001};
         {FACE_XZ, 1'b0}: off = {3'b101, 3'b100, 3'b000};
         {FACE_XZ, 1'b1}: off = {3'b001, 3'b101, 3'b000};
         default:         off = {3'b001, 3'b101, 3'b000};
      endcase
      return off;
   endfunction

   // zero cells count as one
   function automatic logic [CELLS_W-1:0] eff_cells(input logic [CELLS_W-1:0] v);
      return (v == '0) ? CELLS_W'(1) : v;
   endfunction

endpackage
`default_nettype wire

### design/gftg_csr.sv
// Configuration registers of the grid face triangle generator.
`default_nettype none
module gftg_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [gftg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gftg_pkg::SIZE_W-1:0]     csr_data,
   output      gftg_pkg::cfg_type               cfg
);
   import gftg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CELLS_X:   cfg_in.cells_x   = csr_data[CELLS_W-1:0];
            CSR_CELLS_Y:   cfg_in.cells_y   = csr_data[CELLS_W-1:0];
            CSR_CELLS_Z:   cfg_in.cells_z   = csr_data[CELLS_W-1:0];
            CSR_CELL_SIZE: cfg_in.cell_size = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_x   <= CELLS_RESET;
         cfg_ff.cells_y   <= CELLS_RESET;
         cfg_ff.cells_z   <= CELLS_RESET;
         cfg_ff.cell_size <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### design/gftg_walk.sv
// Face walker: index counters and the vertex index stage.
`default_nettype none
module gftg_walk (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gftg_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire logic              restart,
   input  wire logic              drain,
   output      logic              tri_valid,
   output      gftg_pkg::tri_type tri_word
);
   import gftg_pkg::*;

   logic [CELLS_W-1:0] index_i_ff, index_j_ff, index_k_ff;
   logic [CELLS_W-1:0] index_i_in, index_j_in, index_k_in;
   phase_type          phase_ff, phase_in;
   logic               half_ff, half_in;
   logic               valid_ff, valid_in;
   tri_type            tri_ff, tri_in;

   logic [CELLS_W-1:0] cur_i, cur_j, cur_k;
   logic [CELLS_W-1:0] top_i, top_j, top_k;
   phase_type          ph;
   logic               half;
   logic               end_i, end_j, end_k;
   logic [2:0][2:0]    off;
   logic [2:0][CELLS_W-1:0] base;

   always_comb begin
      cur_i = restart ? '0 : index_i_ff;
      cur_j = restart ? '0 : index_j_ff;
      cur_k = restart ? '0 : index_k_ff;
      ph    = restart ? FACE_XY : phase_ff;
      half  = restart ? 1'b0 : half_ff;

      top_i = eff_cells(cfg.cells_x) - CELLS_W'(1) + CELLS_W'(ph == FACE_YZ);
      top_j = eff_cells(cfg.cells_y) - CELLS_W'(1) + CELLS_W'(ph == FACE_XZ);
      top_k = eff_cells(cfg.cells_z) - CELLS_W'(1) + CELLS_W'(ph == FACE_XY);
      end_i = cur_i >= top_i;
      end_j = cur_j >= top_j;
      end_k = cur_k >= top_k;

      off  = vert_off(ph, half);
      base = {cur_k, cur_j, cur_i};
      for (int v = 0; v < 3; v++) begin
         for (int a = 0; a < 3; a++) begin
            tri_in.vidx[v][a] = {1'b0, base[a]} + IDX_W'(off[v][2-a]);
         end
      end
      tri_in.group = ph;
      tri_in.last  = (ph == FACE_XZ) && half && end_i && end_j && end_k;

      index_i_in = cur_i;
      index_j_in = cur_j;
      index_k_in = cur_k;
      phase_in   = ph;
      half_in    = !half;
      if (half) begin
         if (!end_k) begin
            index_k_in = cur_k + CELLS_W'(1);
         end else begin
            index_k_in = '0;
            if (!end_j) begin
               index_j_in = cur_j + CELLS_W'(1);
            end else begin
               index_j_in = '0;
               if (!end_i) begin
                  index_i_in = cur_i + CELLS_W'(1);
               end else begin
                  index_i_in = '0;
                  unique case (ph)
                     FACE_XY: phase_in = FACE_YZ;
                     FACE_YZ: phase_in = FACE_XZ;
                     default: phase_in = FACE_XY;
                  endcase
               end
            end
         end
      end

      valid_in = accept ? 1'b1 : (drain ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_i_ff <= '0;
         index_j_ff <= '0;
         index_k_ff <= '0;
         phase_ff   <= FACE_XY;
         half_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            index_i_ff <= index_i_in;
            index_j_ff <= index_j_in;
            index_k_ff <= index_k_in;
            phase_ff   <= phase_in;
            half_ff    <= half_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tri_ff <= tri_in;
      end
   end

   assign tri_valid = valid_ff;
   assign tri_word  = tri_ff;

endmodule
`default_nettype wire

### design/gftg_scale.sv
// Coordinate scaling by the cell size and the result register.
`default_nettype none
module gftg_scale (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gftg_pkg::cfg_type cfg,
   input  wire logic              tri_valid,
   input  wire gftg_pkg::tri_type tri_word,
   input  wire logic              load,
   output      logic              out_valid,
   output      logic [2:0][2:0][gftg_pkg::COORD_W-1:0] coord,
   output      logic [1:0]        group,
   output      logic              last
);
   import gftg_pkg::*;

   localparam int unsigned PROD_W = SIZE_W + IDX_W;

   logic                         valid_ff;
   logic [2:0][2:0][COORD_W-1:0] coord_ff, coord_in;
   logic [1:0]                   group_ff;
   logic                         last_ff;
   logic [2:0][2:0][PROD_W-1:0]  prod;

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int a = 0; a < 3; a++) begin
            prod[v][a]     = PROD_W'(cfg.cell_size) * PROD_W'(tri_word.vidx[v][a]);
            coord_in[v][a] = prod[v][a][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= tri_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && tri_valid) begin
         coord_ff <= coord_in;
         group_ff <= tri_word.group;
         last_ff  <= tri_word.last;
      end
   end

   assign out_valid = valid_ff;
   assign coord     = coord_ff;
   assign group     = group_ff;
   assign last      = last_ff;

endmodule
`default_nettype wire

### design/grid_face_triangle_generator.sv
// Top level of the grid face triangle generator.
//
//   channel  direction  handshake           word
//   req_     in         req_valid/req_stall restart flag
//   rsp_     out        rsp_valid/rsp_stall three vertices, face group, last flag
//   csr_     in         csr_valid/csr_ready register index and write data
//
// Two register stages: vertex indices, then scaled coordinates.
// One triangle per cycle sustained while rsp_stall is low; the walk counters update on every accepted word.
// Reset (synchronous) returns the walk to the first triangle and loads register defaults.
// rsp_stall holds the result stage and, once both stages are full, raises req_stall.
`default_nettype none
`include "grid_face_triangle_generator_macros.svh"
module grid_face_triangle_generator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_restart,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_first_x,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_first_y,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_first_z,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_second_x,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_second_y,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_second_z,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_third_x,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_third_y,
   output      logic [gftg_pkg::COORD_W-1:0]        rsp_third_z,
   output      logic [1:0]                          rsp_face_group,
   output      logic                                rsp_last,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [gftg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [gftg_pkg::SIZE_W-1:0]         csr_data
);
   import gftg_pkg::*;

   cfg_type                      cfg;
   tri_type                      tri_word;
   logic                         tri_valid;
   logic                         out_ready;
   logic                         in_ready;
   logic                         accept;
   logic [2:0][2:0][COORD_W-1:0] coord;

   assign out_ready = !rsp_valid || !rsp_stall;
   assign in_ready  = !tri_valid || out_ready;
   assign req_stall = !in_ready;
   assign accept    = req_valid && in_ready;

   gftg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gftg_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .restart   (req_restart),
      .drain     (out_ready),
      .tri_valid (tri_valid),
      .tri_word  (tri_word)
   );

   gftg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .tri_valid (tri_valid),
      .tri_word  (tri_word),
      .load      (out_ready),
      .out_valid (rsp_valid),
      .coord     (coord),
      .group     (rsp_face_group),
      .last      (rsp_last)
   );

   assign rsp_first_x  = coord[0][0];
   assign rsp_first_y  = coord[0][1];
   assign rsp_first_z  = coord[0][2];
   assign rsp_second_x = coord[1][0];
   assign rsp_second_y = coord[1][1];
   assign rsp_second_z = coord[1][2];
   assign rsp_third_x  = coord[2][0];
   assign rsp_third_y  = coord[2][1];
   assign rsp_third_z  = coord[2][2];

   `GFTG_ASSERT_IMPLIES(a_last_in_xz, clock, reset, rsp_valid && rsp_last,
      rsp_face_group == FACE_XZ, "last word outside the XZ family")
   `GFTG_ASSERT_IMPLIES(a_xy_flat, clock, reset, rsp_valid && rsp_face_group == FACE_XY,
      rsp_first_z == rsp_second_z && rsp_second_z == rsp_third_z, "XY triangle not flat in z")
   `GFTG_ASSERT_IMPLIES(a_yz_flat, clock, reset, rsp_valid && rsp_face_group == FACE_YZ,
      rsp_first_x == rsp_second_x && rsp_second_x == rsp_third_x, "YZ triangle not flat in x")
   `GFTG_ASSERT_NEVER(a_stall_needs_rsp, clock, reset, req_stall && !rsp_valid,
      "request stalled with empty result stage")

endmodule
`default_nettype wire

### tb/sv/grid_triangle_checker.sv
// Checker for the grid face triangle generator: predicts the face walk and compares each triangle word.
module grid_triangle_checker
   import gftg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic                 req_restart,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [COORD_W-1:0]   rsp_first_x,
   input  wire logic [COORD_W-1:0]   rsp_first_y,
   input  wire logic [COORD_W-1:0]   rsp_first_z,
   input  wire logic [COORD_W-1:0]   rsp_second_x,
   input  wire logic [COORD_W-1:0]   rsp_second_y,
   input  wire logic [COORD_W-1:0]   rsp_second_z,
   input  wire logic [COORD_W-1:0]   rsp_third_x,
   input  wire logic [COORD_W-1:0]   rsp_third_y,
   input  wire logic [COORD_W-1:0]   rsp_third_z,
   input  wire logic [1:0]           rsp_face_group,
   input  wire logic                 rsp_last,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data,
   input  wire logic                 run_done,
   output int                        failures,
   output int                        outstanding
);

   typedef struct packed {
      logic [2:0][2:0][COORD_W-1:0] coord;
      logic [1:0]                   group;
      logic                         last;
   } face_triangle_type;

   string coord_names [9] = '{"first_x", "first_y", "first_z", "second_x", "second_y",
                              "second_z", "third_x", "third_y", "third_z"};

   logic [CELLS_W-1:0] grid_x, grid_y, grid_z;
   logic [SIZE_W-1:0]  cell_len;
   logic [CELLS_W-1:0] walk_i, walk_j, walk_k;
   phase_type          walk_phase;
   logic               walk_half;
   face_triangle_type  pending_triangles [$];
   bit                 leftover_checked;

   function automatic face_triangle_type walk_next_triangle(input logic restart);
      face_triangle_type emitted;
      logic [8:0]     steps;
      logic [8:0]     top_i, top_j, top_k;
      logic [8:0]     corner [3];
      logic [8:0]     pos;
      logic           end_i, end_j, end_k;
      if (restart) begin
         walk_i = '0;
         walk_j = '0;
         walk_k = '0;
         walk_phase = FACE_XY;
         walk_half = 1'b0;
      end
      // three {di,dj,dk} per triangle, first vertex in the top bits
      case (walk_phase)
         FACE_XY: steps = walk_half ? 9'b000_110_100 : 9'b000_010_110;
         FACE_YZ: steps = walk_half ? 9'b001_010_011 : 9'b000_010_001;
         default: steps = walk_half ? 9'b000_101_001 : 9'b000_100_101;
      endcase
      top_i = ((grid_x == '0) ? 9'd1 : {1'b0, grid_x}) - 9'd1 + {8'd0, walk_phase == FACE_YZ};
      top_j = ((grid_y == '0) ? 9'd1 : {1'b0, grid_y}) - 9'd1 + {8'd0, walk_phase == FACE_XZ};
      top_k = ((grid_z == '0) ? 9'd1 : {1'b0, grid_z}) - 9'd1 + {8'd0, walk_phase == FACE_XY};
      corner[0] = {1'b0, walk_i};
      corner[1] = {1'b0, walk_j};
      corner[2] = {1'b0, walk_k};
      for (int v = 0; v < 3; v++) begin
         for (int a = 0; a < 3; a++) begin
            pos = corner[a] + {8'd0, steps[8 - 3 * v - a]};
            emitted.coord[v][a] = COORD_W'(32'(cell_len) * 32'(pos));
         end
      end
      end_i = {1'b0, walk_i} >= top_i;
      end_j = {1'b0, walk_j} >= top_j;
      end_k = {1'b0, walk_k} >= top_k;
      emitted.group = walk_phase;
      emitted.last = (walk_phase == FACE_XZ) && walk_half && end_i && end_j && end_k;
      if (!walk_half) begin
         walk_half = 1'b1;
      end else begin
         walk_half = 1'b0;
         if (!end_k) begin
            walk_k++;
         end else begin
            walk_k = '0;
            if (!end_j) begin
               walk_j++;
            end else begin
               walk_j = '0;
               if (!end_i) begin
                  walk_i++;
               end else begin
                  walk_i = '0;
                  case (walk_phase)
                     FACE_XY: walk_phase = FACE_YZ;
                     FACE_YZ: walk_phase = FACE_XZ;
                     default: walk_phase = FACE_XY;
                  endcase
               end
            end
         end
      end
      return emitted;
   endfunction

   always @(posedge clock) begin
      face_triangle_type seen;
      face_triangle_type want;
      if (reset) begin
         grid_x = CELLS_RESET;
         grid_y = CELLS_RESET;
         grid_z = CELLS_RESET;
         cell_len = SIZE_RESET;
         walk_i = '0;
         walk_j = '0;
         walk_k = '0;
         walk_phase = FACE_XY;
         walk_half = 1'b0;
         pending_triangles.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.coord[0] = {rsp_first_z, rsp_first_y, rsp_first_x};
            seen.coord[1] = {rsp_second_z, rsp_second_y, rsp_second_x};
            seen.coord[2] = {rsp_third_z, rsp_third_y, rsp_third_x};
            seen.group = rsp_face_group;
            seen.last = rsp_last;
            if (pending_triangles.size() == 0) begin
               $error("triangle word with none expected");
               failures++;
            end else begin
               want = pending_triangles.pop_front();
               for (int v = 0; v < 3; v++) begin
                  for (int a = 0; a < 3; a++) begin
                     if (seen.coord[v][a] !== want.coord[v][a]) begin
                        $error("%s: expected %0d, got %0d", coord_names[3 * v + a],
                               want.coord[v][a], seen.coord[v][a]);
                        failures++;
                     end
                  end
               end
               if (seen.group !== want.group) begin
                  $error("face_group: expected %0d, got %0d", want.group, seen.group);
                  failures++;
               end
               if (seen.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, seen.last);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CELLS_X:   grid_x = csr_data[CELLS_W-1:0];
               CSR_CELLS_Y:   grid_y = csr_data[CELLS_W-1:0];
               CSR_CELLS_Z:   grid_z = csr_data[CELLS_W-1:0];
               CSR_CELL_SIZE: cell_len = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pending_triangles.push_back(walk_next_triangle(req_restart));
         end
         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (pending_triangles.size() != 0) begin
               $error("%0d triangle words never arrived", pending_triangles.size());
               failures++;
            end
         end
      end
      outstanding <= pending_triangles.size();
   end

endmodule

### tb/sv/tb.sv
// Testbench top for the grid face triangle generator: clock, reset, stimulus and verdict.
module tb;
   import gftg_pkg::*;

   localparam int unsigned LONG_HOLD      = 120;
   localparam int unsigned QUIET_LIMIT    = 4000;
   localparam int unsigned UNUSED_CSR_LOW = CSR_CELL_SIZE + 1;
   localparam int unsigned RANDOM_WORDS   = 1380;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_restart = 1'b0;
   logic                 rsp_stall = 1'b0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_data = '0;
   logic                 run_done = 1'b0;

   logic                 req_stall;
   logic                 rsp_valid;
   logic [COORD_W-1:0]   rsp_first_x, rsp_first_y, rsp_first_z;
   logic [COORD_W-1:0]   rsp_second_x, rsp_second_y, rsp_second_z;
   logic [COORD_W-1:0]   rsp_third_x, rsp_third_y, rsp_third_z;
   logic [1:0]           rsp_face_group;
   logic                 rsp_last;
   logic                 csr_ready;

   int                   failures;
   int                   outstanding;
   int unsigned          quiet_cycles = 0;
   int unsigned          sent = 0;
   bit                   calm = 1'b0;
   bit                   hold_wanted = 1'b0;

   grid_face_triangle_generator dut (.*);

   grid_triangle_checker checker_inst (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_word(input logic restart);
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // all words accepted and every triangle back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [SIZE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_grid(input logic [SIZE_W-1:0] x, input logic [SIZE_W-1:0] y,
                           input logic [SIZE_W-1:0] z, input logic [SIZE_W-1:0] len);
      write_reg(CSR_CELLS_X, x);
      write_reg(CSR_CELLS_Y, y);
      write_reg(CSR_CELLS_Z, z);
      write_reg(CSR_CELL_SIZE, len);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SIZE_W-1:0] pick_cells();
      logic [CELLS_W-1:0] cells;
      case ($urandom_range(0, 9))
         0:       cells = '0;
         1:       cells = CELLS_W'($urandom_range(4, 12));
         2:       cells = CELLS_W'($urandom_range(13, 255));
         default: cells = CELLS_W'($urandom_range(1, 3));
      endcase
      return {8'($urandom), cells};
   endfunction

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_wanted = 1'b0;
         end else if (!calm && $urandom_range(0, 49) == 0) begin
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int unsigned words;
      bit          gappy;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // default 1x1x1 grid: full walk through all three families, then restarts
      repeat (13) send_word(1'b0);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b1);
      send_word(1'b1);
      drain();

      // largest grid and cell size
      set_grid(16'hFFFF, 16'h5AFF, 16'hA5FF, 16'hFFFF);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b0);
      drain();

      // zero counts read as one, zero cell size, unused register index
      set_grid(16'hFF00, 16'h0100, 16'h8000, 16'h0000);
      write_reg(CSR_IDX_W'(255), 16'hFFFF);
      csr_valid <= 1'b0;
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b0);
      drain();

      // deep walk along z up to the top index, receiver held off at the start
      set_grid(16'h0001, 16'h0001, 16'h00FF, 16'hFFFF);
      hold_wanted = 1'b1;
      send_word(1'b1);
      repeat (539) send_word(1'b0);
      drain();

      while (sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 3) != 0) write_reg(CSR_CELLS_X, pick_cells());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_CELLS_Y, pick_cells());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_CELLS_Z, pick_cells());
         if ($urandom_range(0, 4) == 0) begin
            write_reg(CSR_IDX_W'($urandom_range(UNUSED_CSR_LOW, 255)), SIZE_W'($urandom));
         end
         case ($urandom_range(0, 5))
            0:       write_reg(CSR_CELL_SIZE, '0);
            1:       write_reg(CSR_CELL_SIZE, '1);
            default: write_reg(CSR_CELL_SIZE, SIZE_W'($urandom));
         endcase
         csr_valid <= 1'b0;
         gappy = $urandom_range(0, 3) != 0;
         words = $urandom_range(40, 120);
         // half the phases carry on the walk across the register change
         send_word(1'($urandom_range(0, 1)));
         for (int n = 1; n < words; n++) begin
            if (gappy && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 6));
            send_word($urandom_range(0, 39) == 0);
         end
         drain();
      end

      // closing stretch without idling on either side
      calm = 1'b1;
      repeat (8) @(posedge clock);
      set_grid(16'h0002, 16'h0003, 16'h0002, SIZE_W'($urandom));
      send_word(1'b1);
      repeat (119) send_word($urandom_range(0, 39) == 0);
      drain();

      repeat (8) @(posedge clock);
      run_done <= 1'b1;
      repeat (3) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
